[rtl/udp_congestion_window_control_top_defines.svh]
// assertion macros for the congestion window controller
// used by udp_congestion_window_control_top; expects clk and rst_n in scope
`ifndef UDP_CONGESTION_WINDOW_CONTROL_TOP_DEFINES_SVH
`define UDP_CONGESTION_WINDOW_CONTROL_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define UCWC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define UCWC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/udp_cwc_pkg.sv]
// shared types and constants for the congestion window controller
// no dependencies; used by the channel interfaces and the top level
package udp_cwc_pkg;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned OFF_W    = 32;
  localparam int unsigned TIME_W   = 64;
  localparam int unsigned RTT_W    = 16;
  localparam int unsigned WIN_W    = 14;
  localparam int unsigned RESEND_W = 32;

  // event kinds
  typedef enum logic [OP_W-1:0] {
    OP_INIT   = 3'd0,
    OP_ACK    = 3'd1,
    OP_LOSS   = 3'd2,
    OP_TIMER  = 3'd3,
    OP_RTT    = 3'd4,
    OP_RESEND = 3'd5
  } op_t;

  // window limits
  localparam logic [WIN_W-1:0] WIN_MIN      = 14'd16;
  localparam logic [WIN_W-1:0] CEIL_FAST    = 14'd2048;
  localparam logic [WIN_W-1:0] CEIL_NEAR    = 14'd6144;
  localparam logic [WIN_W-1:0] CEIL_MID     = 14'd8192;
  localparam logic [WIN_W-1:0] CEIL_FAR     = 14'd12288;
  localparam logic [10:0]      RESEND_LIM_MIN = 11'd8;

  // rtt estimator
  localparam logic [RTT_W-1:0] SRTT_INIT    = 16'd50;
  localparam logic [RTT_W-1:0] RTTVAR_INIT  = 16'd25;
  localparam logic [RTT_W-1:0] SRTT_FLOOR   = 16'd5;
  localparam logic [RTT_W-1:0] RTTVAR_FLOOR = 16'd3;
  localparam logic [RTT_W-1:0] SMP_FAST     = 16'd10;
  localparam logic [RTT_W-1:0] SRTT_NEAR    = 16'd50;
  localparam logic [RTT_W-1:0] SRTT_MID     = 16'd100;
  localparam logic [RTT_W-1:0] SRTT_TICK_MIN = 16'd10;
  localparam logic [19:0]      TICK_DELAY_MIN = 20'd100;

  // reciprocals: floor(x/9) = (x*M9)>>20 for x < 2^17, floor(x/5) = (x*M5)>>18
  localparam logic [16:0] M9 = 17'd116509;
  localparam logic [15:0] M5 = 16'd52429;

  localparam logic [1:0] TICK_SAT = 2'd2;

endpackage

[rtl/udp_cwc_in_if.sv]
// event channel: valid/ready handshake with the event fields
// depends on udp_cwc_pkg
interface udp_cwc_in_if;
  import udp_cwc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SEQ_W-1:0]  seq;
  logic              loss_present;
  logic [OFF_W-1:0]  loss_last_offset;
  logic [TIME_W-1:0] now_ms;
  logic [RTT_W-1:0]  rtt_sample;

  modport source (
    output valid, op, seq, loss_present, loss_last_offset, now_ms, rtt_sample,
    input  ready
  );
  modport sink (
    input  valid, op, seq, loss_present, loss_last_offset, now_ms, rtt_sample,
    output ready
  );
endinterface

[rtl/udp_cwc_out_if.sv]
// result channel: valid/ready handshake with window and rtt figures
// depends on udp_cwc_pkg
interface udp_cwc_out_if;
  import udp_cwc_pkg::*;

  logic             valid;
  logic             ready;
  logic [WIN_W-1:0] window;
  logic [WIN_W-1:0] window_ceiling;
  logic [RTT_W-1:0] smoothed_rtt;
  logic [RTT_W-1:0] rtt_variation;
  logic             in_slow_start;

  modport source (
    output valid, window, window_ceiling, smoothed_rtt, rtt_variation, in_slow_start,
    input  ready
  );
  modport sink (
    input  valid, window, window_ceiling, smoothed_rtt, rtt_variation, in_slow_start,
    output ready
  );
endinterface

[rtl/udp_congestion_window_control_top.sv]
// congestion window controller with rtt estimator; uses udp_cwc_pkg, the two channel interfaces
// an accepted event waits in the event register, then its result is registered in the state registers
// throughput: one event per cycle while the result channel is not stalled; the state update sits
//   between the event register and the state registers, which drive the result directly
// reset: synchronous, active low; state takes its initial values, no result pending
module udp_congestion_window_control_top (
  input  logic                clk,
  input  logic                rst_n,
  udp_cwc_in_if.sink          in_ch,
  udp_cwc_out_if.source       out_ch
);
  import udp_cwc_pkg::*;

  `include "udp_congestion_window_control_top_defines.svh"

  // event register
  logic              in_v_r;
  logic [OP_W-1:0]   in_op_r;
  logic [SEQ_W-1:0]  in_seq_r;
  logic              in_present_r;
  logic [OFF_W-1:0]  in_off_r;
  logic [TIME_W-1:0] in_now_r;
  logic [RTT_W-1:0]  in_smp_r;

  // controller state
  logic [WIN_W-1:0]    cwnd_r,       cwnd_nxt;
  logic [WIN_W-1:0]    ceil_r,       ceil_nxt;
  logic [RTT_W-1:0]    srtt_r,       srtt_nxt;
  logic [RTT_W-1:0]    rttvar_r,     rttvar_nxt;
  logic [SEQ_W-1:0]    acked_upto_r, acked_upto_nxt;
  logic [TIME_W-1:0]   last_tick_r,  last_tick_nxt;
  logic                slow_r,       slow_nxt;
  logic                loss_seen_r,  loss_seen_nxt;
  logic                first_rtt_r,  first_rtt_nxt;
  logic [RESEND_W-1:0] resends_r,    resends_nxt;
  logic [1:0]          tick_r,       tick_nxt;
  logic                out_v_r;

  logic adv;

  // handshake: an event moves on when the result slot is free or being taken
  assign adv          = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_op_r      <= in_ch.op;
      in_seq_r     <= in_ch.seq;
      in_present_r <= in_ch.loss_present;
      in_off_r     <= in_ch.loss_last_offset;
      in_now_r     <= in_ch.now_ms;
      in_smp_r     <= in_ch.rtt_sample;
    end
  end

  // ack arithmetic
  logic              ack_new;
  logic [SEQ_W-1:0]  gap;
  logic [WIN_W-1:0]  room;
  logic              gap_fills;
  logic [WIN_W:0]    cwnd_p1;
  logic [WIN_W:0]    grow_sum;
  logic [WIN_W-1:0]  grow_win;

  assign ack_new   = in_seq_r > acked_upto_r;
  assign gap       = in_seq_r - acked_upto_r;
  assign room      = ceil_r - cwnd_r;
  assign gap_fills = (|gap[SEQ_W-1:WIN_W]) || (gap[WIN_W-1:0] >= room);
  assign cwnd_p1   = {1'b0, cwnd_r} + 15'd1;
  assign grow_sum  = {1'b0, cwnd_r} + {1'b0, cwnd_p1[WIN_W:1]};
  assign grow_win  = (grow_sum < {1'b0, ceil_r}) ? grow_sum[WIN_W-1:0] : ceil_r;

  // loss arithmetic: window * 8/9 rounded up
  logic [SEQ_W:0]   loss_last;
  logic             loss_shrink;
  logic [16:0]      loss_num;
  logic [33:0]      loss_prod;
  logic [WIN_W-1:0] loss_q;
  logic [WIN_W-1:0] loss_win;

  assign loss_last   = {1'b0, in_seq_r} + {33'd0, in_off_r};
  assign loss_shrink = in_present_r && ({1'b0, acked_upto_r} < loss_last);
  assign loss_num    = {cwnd_r, 3'b000} + 17'd8;
  assign loss_prod   = {17'd0, loss_num} * {17'd0, M9};
  assign loss_q      = loss_prod[33:20];
  assign loss_win    = (loss_q < WIN_MIN) ? WIN_MIN : loss_q;

  // timer arithmetic
  logic [19:0]       srtt_x10;
  logic [19:0]       delay;
  logic [TIME_W:0]   due;
  logic              tick_fires;
  logic [1:0]        tick_inc;
  logic [10:0]       resend_lim;
  logic              resend_excess;
  logic [15:0]       rs_num;
  logic [31:0]       rs_prod;
  logic [WIN_W-1:0]  rs_q;
  logic [WIN_W-1:0]  rs_win;

  assign srtt_x10      = {1'b0, srtt_r, 3'b000} + {3'b000, srtt_r, 1'b0};
  assign delay         = (srtt_r > SRTT_TICK_MIN) ? srtt_x10 : TICK_DELAY_MIN;
  assign due           = {1'b0, last_tick_r} + {45'd0, delay};
  assign tick_fires    = {1'b0, in_now_r} >= due;
  assign tick_inc      = (tick_r < TICK_SAT) ? tick_r + 2'd1 : tick_r;
  assign resend_lim    = (cwnd_r[WIN_W-1:3] < RESEND_LIM_MIN) ? RESEND_LIM_MIN
                                                              : cwnd_r[WIN_W-1:3];
  assign resend_excess = resends_r > {21'd0, resend_lim};
  assign rs_num        = {cwnd_r, 2'b00} + 16'd4;
  assign rs_prod       = {16'd0, rs_num} * {16'd0, M5};
  assign rs_q          = rs_prod[31:18];
  assign rs_win        = (rs_q < WIN_MIN) ? WIN_MIN : rs_q;

  // rtt estimator arithmetic
  logic [WIN_W-1:0] ceil_pick;
  logic [RTT_W-1:0] rtt_diff;
  logic [17:0]      var_sum;
  logic [18:0]      srtt_sum;
  logic [RTT_W-1:0] srtt_raw;
  logic [RTT_W-1:0] rttvar_raw;

  always_comb begin
    priority if (in_smp_r < SMP_FAST) begin
      ceil_pick = CEIL_FAST;
    end else if (srtt_r < SRTT_NEAR) begin
      ceil_pick = CEIL_NEAR;
    end else if (srtt_r < SRTT_MID) begin
      ceil_pick = CEIL_MID;
    end else begin
      ceil_pick = CEIL_FAR;
    end
  end

  assign rtt_diff   = (srtt_r > in_smp_r) ? srtt_r - in_smp_r : in_smp_r - srtt_r;
  assign var_sum    = {2'b00, rttvar_r} + {1'b0, rttvar_r, 1'b0} + {2'b00, rtt_diff};
  assign srtt_sum   = {srtt_r, 3'b000} - {3'b000, srtt_r} + {3'b000, in_smp_r};
  assign srtt_raw   = first_rtt_r ? in_smp_r : srtt_sum[18:3];
  assign rttvar_raw = first_rtt_r ? {1'b0, in_smp_r[RTT_W-1:1]} : var_sum[17:2];

  // next state per event kind
  always_comb begin
    cwnd_nxt       = cwnd_r;
    ceil_nxt       = ceil_r;
    srtt_nxt       = srtt_r;
    rttvar_nxt     = rttvar_r;
    acked_upto_nxt = acked_upto_r;
    last_tick_nxt  = last_tick_r;
    slow_nxt       = slow_r;
    loss_seen_nxt  = loss_seen_r;
    first_rtt_nxt  = first_rtt_r;
    resends_nxt    = resends_r;
    tick_nxt       = tick_r;
    unique case (op_t'(in_op_r))
      OP_INIT: begin
        cwnd_nxt       = WIN_MIN;
        ceil_nxt       = WIN_MIN;
        srtt_nxt       = SRTT_INIT;
        rttvar_nxt     = RTTVAR_INIT;
        acked_upto_nxt = in_seq_r;
        last_tick_nxt  = in_now_r;
        slow_nxt       = 1'b1;
        loss_seen_nxt  = 1'b0;
        first_rtt_nxt  = 1'b1;
        resends_nxt    = '0;
        tick_nxt       = '0;
      end
      OP_ACK: begin
        if (ack_new) begin
          if (slow_r) begin
            if (gap_fills) begin
              slow_nxt = 1'b0;
              cwnd_nxt = ceil_r;
            end else begin
              cwnd_nxt = cwnd_r + gap[WIN_W-1:0];
            end
          end else if (loss_seen_r) begin
            loss_seen_nxt = 1'b0;
          end else begin
            cwnd_nxt = grow_win;
          end
          acked_upto_nxt = in_seq_r;
        end
      end
      OP_LOSS: begin
        slow_nxt      = 1'b0;
        loss_seen_nxt = 1'b1;
        if (loss_shrink) begin
          cwnd_nxt = loss_win;
        end
      end
      OP_TIMER: begin
        if (tick_fires) begin
          tick_nxt = tick_inc;
          if (slow_r) begin
            if (tick_inc > 2'd1) begin
              slow_nxt = 1'b0;
            end
          end else begin
            if (resend_excess) begin
              cwnd_nxt = rs_win;
            end
            resends_nxt = '0;
          end
          last_tick_nxt = in_now_r;
        end
      end
      OP_RTT: begin
        if (ceil_r == WIN_MIN) begin
          ceil_nxt = ceil_pick;
        end
        first_rtt_nxt = 1'b0;
        srtt_nxt      = (srtt_raw < SRTT_FLOOR) ? SRTT_FLOOR : srtt_raw;
        rttvar_nxt    = (rttvar_raw < RTTVAR_FLOOR) ? RTTVAR_FLOOR : rttvar_raw;
      end
      OP_RESEND: begin
        if (resends_r != '1) begin
          resends_nxt = resends_r + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  // state registers, which also hold the pending result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cwnd_r       <= WIN_MIN;
      ceil_r       <= WIN_MIN;
      srtt_r       <= SRTT_INIT;
      rttvar_r     <= RTTVAR_INIT;
      acked_upto_r <= '0;
      last_tick_r  <= '0;
      slow_r       <= 1'b1;
      loss_seen_r  <= 1'b0;
      first_rtt_r  <= 1'b1;
      resends_r    <= '0;
      tick_r       <= '0;
    end else if (adv) begin
      cwnd_r       <= cwnd_nxt;
      ceil_r       <= ceil_nxt;
      srtt_r       <= srtt_nxt;
      rttvar_r     <= rttvar_nxt;
      acked_upto_r <= acked_upto_nxt;
      last_tick_r  <= last_tick_nxt;
      slow_r       <= slow_nxt;
      loss_seen_r  <= loss_seen_nxt;
      first_rtt_r  <= first_rtt_nxt;
      resends_r    <= resends_nxt;
      tick_r       <= tick_nxt;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.window         = cwnd_r;
  assign out_ch.window_ceiling = ceil_r;
  assign out_ch.smoothed_rtt   = srtt_r;
  assign out_ch.rtt_variation  = rttvar_r;
  assign out_ch.in_slow_start  = slow_r;

  // conditions watched by the checks
  logic                           win_ok;
  logic                           ceil_ok;
  logic                           rtt_ok;
  logic [WIN_W+SEQ_W+RTT_W-1:0]   held_state;

  assign win_ok     = (cwnd_r >= WIN_MIN) && (cwnd_r <= ceil_r);
  assign ceil_ok    = (ceil_r == WIN_MIN) || (ceil_r == CEIL_FAST) || (ceil_r == CEIL_NEAR) ||
                      (ceil_r == CEIL_MID) || (ceil_r == CEIL_FAR);
  assign rtt_ok     = (srtt_r >= SRTT_FLOOR) && (rttvar_r >= RTTVAR_FLOOR);
  assign held_state = {cwnd_r, acked_upto_r, srtt_r};

  // checks on the controller state
  `UCWC_ASSERT_NOW(a_win_range, 1'b1, win_ok, "window out of range")
  `UCWC_ASSERT_NOW(a_ceil_legal, 1'b1, ceil_ok, "illegal window ceiling")
  `UCWC_ASSERT_NOW(a_rtt_floor, 1'b1, rtt_ok, "rtt figures below floor")
  `UCWC_ASSERT_NEXT(a_state_hold, !adv, $stable(held_state), "state moved without an event")

endmodule
